// ===== hw/rtl/led_string_fire_effect_assert.svh =====
// ----------------------------------------------------------------------------
// led_string_fire_effect_assert
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef LED_STRING_FIRE_EFFECT_ASSERT_SVH
`define LED_STRING_FIRE_EFFECT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfe_pkg
// types, constants and arithmetic helpers of the fire effect block
// ----------------------------------------------------------------------------
package lsfe_pkg;

  localparam int          HEAT_W   = 12;
  localparam logic [11:0] HEAT_MAX = 12'd4095;
  localparam logic [6:0]  MAX_PIX  = 7'd64;

  // item codes
  localparam logic [1:0] ACT_ADVANCE = 2'd0;
  localparam logic [1:0] ACT_SPARK   = 2'd1;
  localparam logic [1:0] ACT_RENDER  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FADE_STEP   = 2'd0;
  localparam logic [1:0] REG_SPREAD_THR  = 2'd1;
  localparam logic [1:0] REG_SPREAD_RNG  = 2'd2;
  localparam logic [1:0] REG_DISP_PIXELS = 2'd3;

  // floor(h*rate/10) as h * (rate*52429) >> 19, exact for h below 4096
  localparam logic [18:0] OFFER_K6 = 19'd314574;
  localparam logic [18:0] OFFER_K4 = 19'd209716;
  localparam logic [18:0] OFFER_K2 = 19'd104858;

  // floor(t*c/4095) as t * (c*1048833) >> 32, exact for t below 4096
  localparam logic [27:0] PAL_K64  = 28'd67125312;
  localparam logic [27:0] PAL_K191 = 28'd200327103;
  localparam logic [27:0] PAL_K255 = 28'd267452415;

  localparam logic [11:0] SPARK_BASE = 12'd1229;
  localparam logic [11:0] SPARK_GAIN = 12'd2867;

  typedef struct packed {
    logic [11:0] fade_step;
    logic [11:0] spread_threshold;
    logic [2:0]  spread_range;
    logic [6:0]  display_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic load_item;
    logic idx_clear;
    logic idx_inc;
    logic clr_wr;
    logic cool_wr;
    logic self_ld;
    logic nb_rd;
    logic nb_use;
    logic spr_wr;
    logic spk_rd;
    logic spk_wr;
    logic div_init;
    logic div_step;
    logic pix_init;
    logic pix_rd;
    logic pix_ld;
    logic pix_step;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic range_zero;
    logic nb_last;
    logic div_last;
    logic spark_ok;
    logic pix_last;
    logic out_taken;
  } sts_t;

  function automatic logic [11:0] spread_offer(input logic [11:0] h, input logic [2:0] d);
    logic [18:0] k;
    logic [30:0] p;
    k = (d == 3'd1) ? OFFER_K6 : (d == 3'd2) ? OFFER_K4 : OFFER_K2;
    p = 31'(h) * 31'(k);
    return p[30:19];
  endfunction

  function automatic logic [11:0] spark_heat(input logic [11:0] h, input logic [7:0] e);
    logic [19:0] p;
    logic [12:0] s;
    p = 20'(e) * 20'(SPARK_GAIN);
    s = 13'(h) + 13'(SPARK_BASE) + 13'(p[19:8]);
    return (s > 13'(HEAT_MAX)) ? HEAT_MAX : s[11:0];
  endfunction

  function automatic color_t palette(input logic [11:0] h);
    logic [13:0] u;
    logic [1:0]  k;
    logic [13:0] t;
    logic [27:0] c;
    logic [39:0] p;
    color_t      o;
    u = {h, 2'b00};
    if (u >= 14'd12285) begin
      k = 2'd3;
    end else if (u >= 14'd8190) begin
      k = 2'd2;
    end else if (u >= 14'd4095) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    t = u - 14'(k) * 14'(HEAT_MAX);
    case (k)
      2'd0:    c = PAL_K64;
      2'd1:    c = PAL_K191;
      default: c = PAL_K255;
    endcase
    p = 40'(t[11:0]) * 40'(c);
    o = '0;
    case (k)
      2'd0: begin
        o.red = p[39:32];
      end
      2'd1: begin
        o.red = 8'd64 + p[39:32];
      end
      2'd2: begin
        o.red   = 8'd255;
        o.green = p[39:32];
      end
      default: begin
        o.red   = 8'd255;
        o.green = 8'd255;
        o.blue  = p[39:32];
      end
    endcase
    return o;
  endfunction

endpackage

// ===== hw/rtl/lsfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsfe_ctrl
// sequencer: clearing pass, cool and spread sweeps, spark, render
// ----------------------------------------------------------------------------
module lsfe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_action,
  output logic          in_ready,
  input  lsfe_pkg::sts_t sts,
  output lsfe_pkg::cmd_t cmd
);
  import lsfe_pkg::*;

  typedef enum logic [15:0] {
    ST_CLR      = 16'h0001,
    ST_IDLE     = 16'h0002,
    ST_COOL_RD  = 16'h0004,
    ST_COOL_WR  = 16'h0008,
    ST_SELF_RD  = 16'h0010,
    ST_SELF_LD  = 16'h0020,
    ST_NB_RD    = 16'h0040,
    ST_NB_USE   = 16'h0080,
    ST_SPR_WR   = 16'h0100,
    ST_SPK_RD   = 16'h0200,
    ST_SPK_WR   = 16'h0400,
    ST_DIV      = 16'h0800,
    ST_PIX_INIT = 16'h1000,
    ST_PIX_RD   = 16'h2000,
    ST_PIX_LD   = 16'h4000,
    ST_PIX_WAIT = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_action)
            ACT_ADVANCE: state_nxt = ST_COOL_RD;
            ACT_SPARK:   state_nxt = ST_SPK_RD;
            ACT_RENDER: begin
              cmd.div_init = 1'b1;
              state_nxt    = ST_DIV;
            end
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_COOL_RD: state_nxt = ST_COOL_WR;
      ST_COOL_WR: begin
        cmd.cool_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_SELF_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_COOL_RD;
        end
      end
      ST_SELF_RD: state_nxt = ST_SELF_LD;
      ST_SELF_LD: begin
        cmd.self_ld = 1'b1;
        state_nxt   = sts.range_zero ? ST_SPR_WR : ST_NB_RD;
      end
      ST_NB_RD: begin
        cmd.nb_rd = 1'b1;
        state_nxt = ST_NB_USE;
      end
      ST_NB_USE: begin
        cmd.nb_use = 1'b1;
        state_nxt  = sts.nb_last ? ST_SPR_WR : ST_NB_RD;
      end
      ST_SPR_WR: begin
        cmd.spr_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SELF_RD;
        end
      end
      ST_SPK_RD: begin
        cmd.spk_rd = 1'b1;
        state_nxt  = ST_SPK_WR;
      end
      ST_SPK_WR: begin
        cmd.spk_wr = sts.spark_ok;
        state_nxt  = ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_PIX_INIT;
        end
      end
      ST_PIX_INIT: begin
        cmd.pix_init = 1'b1;
        state_nxt    = ST_PIX_RD;
      end
      ST_PIX_RD: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = ST_PIX_LD;
      end
      ST_PIX_LD: begin
        cmd.pix_ld = 1'b1;
        state_nxt  = ST_PIX_WAIT;
      end
      ST_PIX_WAIT: begin
        if (sts.out_taken) begin
          if (sts.pix_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.pix_step = 1'b1;
            state_nxt    = ST_PIX_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/lsfe_dp.sv =====
// ----------------------------------------------------------------------------
// lsfe_dp
// heat and cooled-copy memories, spread accumulator, divider, pixel output
// ----------------------------------------------------------------------------
module lsfe_dp #(
  parameter int CELL_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lsfe_pkg::cfg_t cfg,
  input  lsfe_pkg::cmd_t cmd,
  output lsfe_pkg::sts_t sts,
  input  logic [5:0]     in_spark_position,
  input  logic [7:0]     in_energy,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [5:0]     out_pixel_index,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic           out_last_pixel
);
  import lsfe_pkg::*;

  localparam int AW = $clog2(CELL_COUNT);
  localparam int NW = AW + 4;
  localparam int DW = $clog2(CELL_COUNT + 1);
  localparam int CW = $clog2(DW);

  logic [HEAT_W-1:0] heat_mem [CELL_COUNT];
  logic [HEAT_W-1:0] src_mem  [CELL_COUNT];

  logic [AW-1:0]     idx_r;
  logic [5:0]        pos_r;
  logic [7:0]        energy_r;
  logic [HEAT_W-1:0] heat_rd_r, src_rd_r, acc_r;
  logic [2:0]        d_r;
  logic              side_r, nb_ok_r;
  logic [6:0]        n_r, r_r, frac_r;
  logic [DW-1:0]     q_r;
  logic [CW-1:0]     dcnt_r;
  logic [AW-1:0]     cell_r;
  logic [5:0]        x_r;
  logic              out_valid_r, out_last_r;
  logic [5:0]        out_pix_r;
  color_t            out_col_r;

  // neighbor address for the spread gather
  logic [NW-1:0] j_ext, d_ext, nb_up, nb_dn;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;

  assign j_ext   = NW'(idx_r);
  assign d_ext   = NW'(d_r);
  assign nb_up   = j_ext + d_ext;
  assign nb_dn   = j_ext - d_ext;
  assign nb_ok   = side_r ? (nb_up < NW'(CELL_COUNT)) : (j_ext >= d_ext);
  assign nb_addr = !nb_ok ? idx_r : (side_r ? nb_up[AW-1:0] : nb_dn[AW-1:0]);

  logic spark_ok;
  assign spark_ok = (32'(pos_r) < 32'(CELL_COUNT));

  // memory ports
  logic [AW-1:0]     heat_raddr, heat_waddr, src_raddr;
  logic              heat_we;
  logic [HEAT_W-1:0] heat_wdata, cooled;

  assign cooled = (heat_rd_r >= cfg.fade_step) ? heat_rd_r - cfg.fade_step : '0;

  always_comb begin
    if (cmd.spk_rd) begin
      heat_raddr = spark_ok ? AW'(pos_r) : '0;
    end else if (cmd.pix_rd) begin
      heat_raddr = cell_r;
    end else begin
      heat_raddr = idx_r;
    end
    heat_we    = cmd.clr_wr | cmd.spr_wr | cmd.spk_wr;
    heat_waddr = cmd.spk_wr ? AW'(pos_r) : idx_r;
    if (cmd.spk_wr) begin
      heat_wdata = spark_heat(heat_rd_r, energy_r);
    end else if (cmd.spr_wr) begin
      heat_wdata = acc_r;
    end else begin
      heat_wdata = '0;
    end
    src_raddr = cmd.nb_rd ? nb_addr : idx_r;
  end

  always_ff @(posedge clk) begin
    heat_rd_r <= heat_mem[heat_raddr];
    if (heat_we) begin
      heat_mem[heat_waddr] <= heat_wdata;
    end
  end

  always_ff @(posedge clk) begin
    src_rd_r <= src_mem[src_raddr];
    if (cmd.cool_wr) begin
      src_mem[idx_r] <= cooled;
    end
  end

  // sweep index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clear) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pos_r    <= in_spark_position;
      energy_r <= in_energy;
    end
  end

  // spread gather: max of own cooled heat and offers from neighbors
  logic [HEAT_W-1:0] offer;
  assign offer = spread_offer(src_rd_r, d_r);

  always_ff @(posedge clk) begin
    if (cmd.self_ld) begin
      acc_r  <= src_rd_r;
      d_r    <= 3'd1;
      side_r <= 1'b0;
    end else if (cmd.nb_use) begin
      if (nb_ok_r && (src_rd_r > cfg.spread_threshold) && (offer > acc_r)) begin
        acc_r <= offer;
      end
      if (side_r) begin
        side_r <= 1'b0;
        d_r    <= d_r + 3'd1;
      end else begin
        side_r <= 1'b1;
      end
    end
    if (cmd.nb_rd) begin
      nb_ok_r <= nb_ok;
    end
  end

  // restoring divider: CELL_COUNT / n, one quotient bit per beat
  logic [7:0] dtrial, n_ext;
  logic       dge;
  assign n_ext  = {1'b0, n_r};
  assign dtrial = {r_r, q_r[DW-1]};
  assign dge    = (dtrial >= n_ext);

  // pixel to cell step: cell advances by quotient, remainder carries
  logic [7:0]  fsum;
  logic        fwrap;
  logic [DW:0] cell_sum;
  assign fsum     = {1'b0, frac_r} + {1'b0, r_r};
  assign fwrap    = (fsum >= n_ext);
  assign cell_sum = (DW+1)'(cell_r) + (DW+1)'(q_r) + (DW+1)'(fwrap);

  logic pix_last;
  assign pix_last = ({1'b0, x_r} == (n_r - 7'd1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      if (cfg.display_pixels == 7'd0) begin
        n_r <= 7'd1;
      end else if (cfg.display_pixels > MAX_PIX) begin
        n_r <= MAX_PIX;
      end else begin
        n_r <= cfg.display_pixels;
      end
      q_r    <= DW'(CELL_COUNT);
      r_r    <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      r_r    <= dge ? 7'(dtrial - n_ext) : dtrial[6:0];
      q_r    <= {q_r[DW-2:0], dge};
      dcnt_r <= dcnt_r + CW'(1);
    end
    if (cmd.pix_init) begin
      cell_r <= '0;
      frac_r <= '0;
      x_r    <= '0;
    end else if (cmd.pix_step) begin
      cell_r <= cell_sum[AW-1:0];
      frac_r <= fwrap ? 7'(fsum - n_ext) : fsum[6:0];
      x_r    <= x_r + 6'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pix_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_ld) begin
      out_pix_r  <= x_r;
      out_col_r  <= palette(heat_rd_r);
      out_last_r <= pix_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pix_r;
  assign out_red         = out_col_r.red;
  assign out_green       = out_col_r.green;
  assign out_blue        = out_col_r.blue;
  assign out_last_pixel  = out_last_r;

  assign sts.idx_last   = (idx_r == AW'(CELL_COUNT - 1));
  assign sts.range_zero = (cfg.spread_range == 3'd0);
  assign sts.nb_last    = side_r && (d_r == cfg.spread_range);
  assign sts.div_last   = (dcnt_r == CW'(DW - 1));
  assign sts.spark_ok   = spark_ok;
  assign sts.pix_last   = pix_last;
  assign sts.out_taken  = out_valid_r & out_ready;

endmodule

// ===== hw/rtl/led_string_fire_effect.sv =====
// ----------------------------------------------------------------------------
// led_string_fire_effect
// one-dimensional fire: a row of heat cells, sparks, and palette render
// ----------------------------------------------------------------------------
// After reset the block clears the heat memory and takes no item until that
// is done. Items are worked one at a time. A spark reads its cell and writes
// the raised heat back. An advance sweeps the row twice through the heat and
// cooled-copy memories, each with one read and one write port: first to cool,
// then to gather neighbor heat, two memory reads per neighbor distance. A
// render runs a bit-serial divider, then emits its pixels one at a time; each
// pixel waits in the output register until taken.
module led_string_fire_effect #(
  parameter int CELL_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_spark_position,
  input  logic [7:0]  in_energy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsfe_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_step        <= 12'd123;
      cfg_r.spread_threshold <= 12'd82;
      cfg_r.spread_range     <= 3'd3;
      cfg_r.display_pixels   <= 7'd64;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_FADE_STEP:   cfg_r.fade_step        <= pwdata[11:0];
        REG_SPREAD_THR:  cfg_r.spread_threshold <= pwdata[11:0];
        REG_SPREAD_RNG:  cfg_r.spread_range     <= pwdata[2:0];
        REG_DISP_PIXELS: cfg_r.display_pixels   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FADE_STEP:   prdata = 32'(cfg_r.fade_step);
      REG_SPREAD_THR:  prdata = 32'(cfg_r.spread_threshold);
      REG_SPREAD_RNG:  prdata = 32'(cfg_r.spread_range);
      REG_DISP_PIXELS: prdata = 32'(cfg_r.display_pixels);
      default:         prdata = '0;
    endcase
  end

  lsfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsfe_dp #(
    .CELL_COUNT (CELL_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .sts               (sts),
    .in_spark_position (in_spark_position),
    .in_energy         (in_energy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_index   (out_pixel_index),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

// ===== hw/rtl/lsfe_checker.sv =====
// ----------------------------------------------------------------------------
// lsfe_checker
// port-level checks of the fire effect block, bound to the top level
// ----------------------------------------------------------------------------
`include "led_string_fire_effect_assert.svh"

module lsfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_pixel_index,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_last_pixel
);

  // a stalled pixel beat holds
  `LSFE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_index) && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_last_pixel), "stalled pixel changed")

  // new items are taken only with no pixel pending
  `LSFE_ASSERT_IMP(a_ready_no_out, in_ready, !out_valid, "ready while a pixel is pending")

  // a render keeps going until its last pixel
  `LSFE_ASSERT_NXT(a_render_busy, out_valid && out_ready && !out_last_pixel, !in_ready, "ready in the middle of a render")

  // the last pixel frees the block
  `LSFE_ASSERT_NXT(a_render_done, out_valid && out_ready && out_last_pixel, in_ready, "not ready after the last pixel")

endmodule

bind led_string_fire_effect lsfe_checker u_lsfe_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// fire effect block: directed table then random sparks, advances and renders,
// pixels checked against a behavioral model of the heat row and palette
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsfe_pkg::*;

  localparam int CELLS = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [5:0]  in_spark_position = '0;
  logic [7:0]  in_energy = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_pixel_index;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_last_pixel;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  led_string_fire_effect dut (.*);

  always #1 clk = ~clk;

  typedef struct {
    logic [5:0] idx;
    logic [7:0] r, g, b;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [1:0] act;
    logic [5:0] pos;
    logic [7:0] en;
    logic       typed;  // first pixel typed in below
    logic [7:0] r0, g0, b0;
  } row_t;

  logic [11:0] heat [CELLS];
  logic [11:0] fade, thr;
  logic [2:0]  rng;
  logic [6:0]  npix;
  pixel_t      pixels_due[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 0;      // no idling in the final stretch
  bit          hold_out = 0;
  int          gap_left = 0;
  int          out_gap = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic void heat_advance();
    logic [11:0] src [CELLS];
    int o;
    for (int i = 0; i < CELLS; i++) begin
      heat[i] = (heat[i] >= fade) ? heat[i] - fade : 12'd0;
      src[i] = heat[i];
    end
    for (int i = 0; i < CELLS; i++) begin
      if (src[i] <= thr) continue;
      for (int d = 1; d <= rng; d++) begin
        o = (int'(src[i]) * ((d == 1) ? 6 : (d == 2) ? 4 : 2)) / 10;
        if (i >= d && heat[i-d] < o) heat[i-d] = 12'(o);
        if (i + d < CELLS && heat[i+d] < o) heat[i+d] = 12'(o);
      end
    end
  endfunction

  function automatic void heat_render();
    int n, c, u, k, t;
    pixel_t p;
    n = (npix == 0) ? 1 : (npix > 64) ? 64 : npix;
    for (int x = 0; x < n; x++) begin
      c = x * CELLS / n;
      u = 4 * heat[c];
      k = u / 4095;
      if (k > 3) k = 3;
      t = u - k * 4095;
      p.idx = 6'(x); p.g = '0; p.b = '0;
      case (k)
        0: p.r = 8'(t * 64 / 4095);
        1: p.r = 8'(64 + t * 191 / 4095);
        2: begin p.r = 8'd255; p.g = 8'(t * 255 / 4095); end
        default: begin p.r = 8'd255; p.g = 8'd255; p.b = 8'(t * 255 / 4095); end
      endcase
      p.last = (x + 1 == n);
      pixels_due.push_back(p);
    end
  endfunction

  function automatic void predict(input logic [1:0] a, input logic [5:0] pos,
                                  input logic [7:0] e);
    int v;
    case (a)
      ACT_ADVANCE: heat_advance();
      ACT_SPARK: begin
        v = heat[pos] + 1229 + ((2867 * e) >> 8);
        heat[pos] = (v > 4095) ? 12'd4095 : 12'(v);
      end
      ACT_RENDER: heat_render();
      default: ;
    endcase
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_FADE_STEP:  fade = val[11:0];
      REG_SPREAD_THR: thr = val[11:0];
      REG_SPREAD_RNG: rng = val[2:0];
      default:        npix = val[6:0];
    endcase
  endtask

  task automatic drain();
    while (pixels_due.size() != 0) @(negedge clk);
    // an advance can still be running with nothing due
    repeat (64 * 32 + 200) @(negedge clk);
  endtask

  task automatic send(input logic [1:0] a, input logic [5:0] pos, input logic [7:0] e);
    if (!quiet && gap_left == 0 && $urandom_range(0, 5) == 0)
      gap_left = $urandom_range(1, 11);
    while (gap_left > 0) begin
      @(negedge clk);
      gap_left--;
    end
    in_valid = 1; in_action = a; in_spark_position = pos; in_energy = e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(a, pos, e);
    @(negedge clk);
    in_valid = 0;
  endtask

  // receiver side, with random idle bursts
  always @(negedge clk) begin
    if (hold_out) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   <= out_gap - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_gap   <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        report("pixel beat with none due", out_pixel_index, -1);
      end else begin
        w = pixels_due.pop_front();
        if (out_pixel_index !== w.idx) report("pixel_index", out_pixel_index, w.idx);
        if (out_red !== w.r) report("red", out_red, w.r);
        if (out_green !== w.g) report("green", out_green, w.g);
        if (out_blue !== w.b) report("blue", out_blue, w.b);
        if (out_last_pixel !== w.last) report("last_pixel", out_last_pixel, w.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  row_t tbl [] = '{
    '{ACT_RENDER,  6'd0,  8'd0,   1, 8'd0,   8'd0,   8'd0},   // all cold after reset
    '{ACT_SPARK,   6'd0,  8'd255, 0, 0, 0, 0},
    '{ACT_SPARK,   6'd0,  8'd255, 0, 0, 0, 0},                // clamps at full heat
    '{ACT_RENDER,  6'd0,  8'd0,   1, 8'd255, 8'd255, 8'd255}, // white at full
    '{ACT_SPARK,   6'd63, 8'd0,   0, 0, 0, 0},
    '{ACT_SPARK,   6'd31, 8'd128, 0, 0, 0, 0},
    '{ACT_UNKNOWN, 6'd63, 8'd255, 0, 0, 0, 0},                // ignored
    '{ACT_ADVANCE, 6'd0,  8'd0,   0, 0, 0, 0},
    '{ACT_RENDER,  6'd0,  8'd0,   0, 0, 0, 0},
    '{ACT_ADVANCE, 6'd17, 8'd1,   0, 0, 0, 0},
    '{ACT_SPARK,   6'd42, 8'd1,   0, 0, 0, 0},
    '{ACT_RENDER,  6'd0,  8'd0,   0, 0, 0, 0}
  };

  task automatic rand_item();
    int sel;
    logic [1:0] a;
    sel = $urandom_range(0, 19);
    a = (sel < 9) ? ACT_SPARK : (sel < 14) ? ACT_ADVANCE : (sel < 19) ? ACT_RENDER
        : ACT_UNKNOWN;
    send(a, 6'($urandom), 8'($urandom));
  endtask

  initial begin
    pixel_t w;
    fade = 123; thr = 82; rng = 3; npix = 64;
    for (int i = 0; i < CELLS; i++) heat[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (tbl[i]) begin
      if (tbl[i].typed) begin
        send(tbl[i].act, tbl[i].pos, tbl[i].en);
        w = pixels_due[pixels_due.size() - 64];
        if (w.r !== tbl[i].r0 || w.g !== tbl[i].g0 || w.b !== tbl[i].b0)
          report("table row colour", i, -1);
      end else begin
        send(tbl[i].act, tbl[i].pos, tbl[i].en);
      end
    end
    drain();

    // config phases, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cfg_write(REG_FADE_STEP, 0); cfg_write(REG_SPREAD_THR, 0);
                 cfg_write(REG_SPREAD_RNG, 7); cfg_write(REG_DISP_PIXELS, 0); end
        1: begin cfg_write(REG_FADE_STEP, 4095); cfg_write(REG_SPREAD_THR, 4095);
                 cfg_write(REG_SPREAD_RNG, 0); cfg_write(REG_DISP_PIXELS, 127); end
        2: begin cfg_write(REG_FADE_STEP, 40); cfg_write(REG_SPREAD_THR, 300);
                 cfg_write(REG_SPREAD_RNG, 1); cfg_write(REG_DISP_PIXELS, 1); end
        3: begin cfg_write(REG_FADE_STEP, $urandom_range(0, 4095));
                 cfg_write(REG_SPREAD_THR, $urandom_range(0, 4095));
                 cfg_write(REG_SPREAD_RNG, $urandom_range(0, 7));
                 cfg_write(REG_DISP_PIXELS, $urandom_range(1, 64)); end
        4: begin cfg_write(REG_FADE_STEP, 123); cfg_write(REG_SPREAD_THR, 82);
                 cfg_write(REG_SPREAD_RNG, 2); cfg_write(REG_DISP_PIXELS, 17); end
        default: begin cfg_write(REG_SPREAD_RNG, 3); cfg_write(REG_DISP_PIXELS, 64); end
      endcase
      if (ph == 4) begin
        // long receiver stall while items keep coming
        fork
          begin hold_out = 1; repeat (600) @(negedge clk); hold_out = 0; end
          repeat (8) send(ACT_RENDER, 0, 0);
        join
      end
      if (ph == 5) quiet = 1;
      repeat (50) rand_item();
      drain();
    end

    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lsfe_pkg.sv
hw/rtl/lsfe_ctrl.sv
hw/rtl/lsfe_dp.sv
hw/rtl/led_string_fire_effect.sv
hw/rtl/lsfe_checker.sv
tb/testbench.sv
